// ===== rtl/hars_pkg.sv =====
package hars_pkg;

    // Protocol states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WAIT  = 2'd1;
    localparam logic [1:0] ST_DELAY = 2'd2;

    // Error event codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NAK     = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;

    localparam logic [7:0] ACK_BYTE = 8'h66;

    // Configuration register indexes
    localparam logic [7:0] REG_HEARTBEAT = 8'd0;
    localparam logic [7:0] REG_ACK_TMO   = 8'd1;
    localparam logic [7:0] REG_RETRY_DLY = 8'd2;
    localparam logic [7:0] REG_RETRY_LIM = 8'd3;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic       send_packet;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [1:0] error_event;
    } result_t;

endpackage

// ===== rtl/heartbeat_ack_retry_sender.sv =====
// One input beat per cycle while s_tready is high; the state update is a single
// registered pass (saturating timer increment, one interval compare, next-state select),
// and each accepted beat's result is registered in the output or the skid register.
// A two-entry output (result register plus skid register) keeps s_tready high while
// one result waits. Reset (rst_n low, asynchronous) returns to idle with cleared timer
// and retry count, empty output, and register defaults 1000, 100, 200 and 3.
module heartbeat_ack_retry_sender #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] rx_byte, [8] power_on_request, [9] fan_on_request, [10] heat_request,
    // [11] fire_alarm, [15:12] zero
    input  logic [hars_pkg::IN_DATA_W-1:0]    s_tdata,
    // [0] byte_valid
    input  logic                              s_tuser,
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] first_byte, [15:8] second_byte, [17:16] error_event, [23:18] zero
    output logic [hars_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] send_packet
    output logic                              m_tuser,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hars_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hars_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hars_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    logic [15:0]            heartbeat_reg;
    logic [15:0]            ack_tmo_reg;
    logic [15:0]            retry_dly_reg;
    logic [7:0]             retry_lim_reg;

    logic [1:0]             state_reg, state_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [7:0]             retries_reg, retries_next;

    logic                   out_valid_reg;
    result_t                out_reg;
    logic                   skid_valid_reg;
    result_t                skid_reg;

    logic                   in_fire;
    logic                   byte_valid;
    logic [7:0]             rx_byte;
    logic [3:0]             flags;
    logic [TIMER_WIDTH-1:0] tick;
    logic [CMP_W-1:0]       tick_ext;
    logic                   hb_done, tmo_done, dly_done;
    logic                   send, changed;
    logic [1:0]             err;
    result_t                res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;

    assign byte_valid = s_tuser;
    assign rx_byte    = s_tdata[7:0];
    assign flags      = {s_tdata[8], s_tdata[9], s_tdata[10], s_tdata[11]};

    assign tick     = (elapsed_reg == TIMER_MAX) ? elapsed_reg : elapsed_reg + TIMER_WIDTH'(1);
    assign tick_ext = CMP_W'(tick);
    assign hb_done  = tick_ext >= CMP_W'(heartbeat_reg);
    assign tmo_done = tick_ext >= CMP_W'(ack_tmo_reg);
    assign dly_done = tick_ext >= CMP_W'(retry_dly_reg);

    always_comb
    begin
        state_next   = state_reg;
        retries_next = retries_reg;
        send         = 1'b0;
        changed      = 1'b0;
        err          = ERR_NONE;
        case (state_reg)
            ST_WAIT:
            begin
                if (byte_valid)
                begin
                    changed = 1'b1;
                    if (rx_byte == ACK_BYTE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        err        = ERR_NAK;
                        state_next = ST_DELAY;
                    end
                end
                else if (tmo_done)
                begin
                    changed = 1'b1;
                    err     = ERR_TIMEOUT;
                    if (retries_reg < retry_lim_reg)
                    begin
                        retries_next = retries_reg + 8'd1;
                        send         = 1'b1;
                        state_next   = ST_WAIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DELAY:
            begin
                // bytes arriving here are dropped
                if (dly_done)
                begin
                    changed    = 1'b1;
                    send       = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default:
            begin
                if (byte_valid)
                begin
                    changed    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (hb_done)
                begin
                    changed      = 1'b1;
                    send         = 1'b1;
                    retries_next = 8'd0;
                    state_next   = ST_WAIT;
                end
            end
        endcase
        elapsed_next = changed ? '0 : tick;

        res.send_packet = send;
        res.first_byte  = send ? {flags, ~flags} : 8'd0;
        res.second_byte = send ? {~flags, flags} : 8'd0;
        res.error_event = err;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heartbeat_reg <= 16'd1000;
            ack_tmo_reg   <= 16'd100;
            retry_dly_reg <= 16'd200;
            retry_lim_reg <= 8'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEARTBEAT: heartbeat_reg <= cfg_data;
                REG_ACK_TMO:   ack_tmo_reg   <= cfg_data;
                REG_RETRY_DLY: retry_dly_reg <= cfg_data;
                REG_RETRY_LIM: retry_lim_reg <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // protocol state, advanced once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            retries_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            retries_reg <= retries_next;
        end
    end

    // output and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.send_packet;
    assign m_tdata  = {6'd0, out_reg.error_event, out_reg.second_byte, out_reg.first_byte};

endmodule
